// ===== rtl/tgr_pkg.sv =====
// Shared types and constants for the touch gesture recognizer.
// Holds the poll and result payload structs, register indexes and gesture codes.
// No dependencies.
package tgr_pkg;

	localparam int unsigned POS_X_W = 9;
	localparam int unsigned POS_Y_W = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [POS_X_W-1:0] SCREEN_MAX_X = 9'd319;
	localparam logic [POS_Y_W-1:0] SCREEN_MAX_Y = 8'd239;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_ENABLED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_FLIP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_TRAVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_TOLERANCE = 3'd4;

	// Gesture codes.
	localparam logic [1:0] G_LONG = 2'd0;
	localparam logic [1:0] G_LEFT = 2'd1;
	localparam logic [1:0] G_RIGHT = 2'd2;
	localparam logic [1:0] G_TAP = 2'd3;

	typedef struct packed {
		logic        buffer_ready;
		logic [3:0]  point_count;
		logic [15:0] raw_x;
		logic [15:0] raw_y;
		logic [31:0] time_ms;
	} poll_t;

	typedef struct packed {
		logic [1:0]         gesture;
		logic [POS_X_W-1:0] pos_x;
		logic [POS_Y_W-1:0] pos_y;
	} result_t;

	typedef struct packed {
		logic [POS_X_W-1:0] x;
		logic [POS_Y_W-1:0] y;
	} point_t;

	// A poll after coordinate mapping, as held in the first stage.
	typedef struct packed {
		logic        touch;
		point_t      pos;
		logic [31:0] time_ms;
	} mapped_poll_t;

	// Gesture thresholds handed from the register file to the core.
	typedef struct packed {
		logic        touch_enabled;
		logic [15:0] hold_time;
		logic [8:0]  swipe_travel;
		logic [7:0]  tap_tolerance;
		logic [15:0] tap_tolerance_sq;
	} gesture_cfg_t;

endpackage

// ===== rtl/touch_gesture_recognizer_unit.sv =====
// Top level of the touch gesture recognizer: register file, poll stage and core.
// Depends on tgr_pkg, tgr_coord_map and tgr_gesture_core.
//
//   channel   direction  handshake                     payload
//   poll      in         poll_valid / poll_ready       poll_data (poll_t)
//   result    out        result_valid / result_ready   result_data (result_t)
//   config    in         cfg_we                        cfg_index, cfg_wdata
//
// A poll is mapped to landscape and registered in the cycle it transfers, then
// decided once the result slot is free, with any gesture landing in the result register.
// One poll per cycle is taken while no result is stalled; a fired gesture sets result_valid.
// Reset clears the press state and loads the register defaults; no clearing pass.
// A stalled result holds the poll stage, which in turn drops poll_ready.
module touch_gesture_recognizer_unit
	import tgr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  poll_valid,
	output logic                  poll_ready,
	input  poll_t                 poll_data,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic         touch_enabled_q;
	logic         rotation_flip_q;
	logic [15:0]  hold_time_q;
	logic [8:0]   swipe_travel_q;
	logic [7:0]   tap_tolerance_q;
	logic [15:0]  tap_tolerance_sq_q;
	logic         valid_s1;
	mapped_poll_t poll_s1;
	mapped_poll_t mapped;
	logic         advance;
	gesture_cfg_t cfg;

	// The squared tolerance is formed at write time to keep it off the decision path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_enabled_q <= 1'b1;
			rotation_flip_q <= 1'b1;
			hold_time_q <= 16'd600;
			swipe_travel_q <= 9'd60;
			tap_tolerance_q <= 8'd12;
			tap_tolerance_sq_q <= 16'd144;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOUCH_ENABLED: touch_enabled_q <= cfg_wdata[0];
				CFG_ROTATION_FLIP: rotation_flip_q <= cfg_wdata[0];
				CFG_HOLD_TIME: hold_time_q <= cfg_wdata;
				CFG_SWIPE_TRAVEL: swipe_travel_q <= cfg_wdata[8:0];
				CFG_TAP_TOLERANCE: begin
					tap_tolerance_q <= cfg_wdata[7:0];
					tap_tolerance_sq_q <= {8'd0, cfg_wdata[7:0]} * {8'd0, cfg_wdata[7:0]};
				end
				default: ;
			endcase
		end
	end

	assign cfg.touch_enabled = touch_enabled_q;
	assign cfg.hold_time = hold_time_q;
	assign cfg.swipe_travel = swipe_travel_q;
	assign cfg.tap_tolerance = tap_tolerance_q;
	assign cfg.tap_tolerance_sq = tap_tolerance_sq_q;

	tgr_coord_map u_map (
		.poll          (poll_data),
		.rotation_flip (rotation_flip_q),
		.mapped        (mapped)
	);

	assign poll_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_ready) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && poll_ready) begin
			poll_s1 <= mapped;
		end
	end

	tgr_gesture_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.valid_s1     (valid_s1),
		.poll_s1      (poll_s1),
		.advance      (advance),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

// ===== rtl/tgr_coord_map.sv =====
// Portrait to landscape coordinate mapping with mirroring and clamping.
// Depends on tgr_pkg.
module tgr_coord_map
	import tgr_pkg::*;
(
	input  poll_t        poll,
	input  logic         rotation_flip,
	output mapped_poll_t mapped
);

	logic ry_over;
	logic rx_over;
	logic [POS_X_W-1:0] sx;
	logic [POS_Y_W-1:0] sy;

	assign ry_over = poll.raw_y > {7'd0, SCREEN_MAX_X};
	assign rx_over = poll.raw_x > {8'd0, SCREEN_MAX_Y};

	// The mirrored value saturates instead of wrapping when the raw value is out of range.
	always_comb begin
		if (rotation_flip) begin
			sx = ry_over ? '0 : SCREEN_MAX_X - poll.raw_y[POS_X_W-1:0];
			sy = rx_over ? SCREEN_MAX_Y : poll.raw_x[POS_Y_W-1:0];
		end else begin
			sx = ry_over ? SCREEN_MAX_X : poll.raw_y[POS_X_W-1:0];
			sy = rx_over ? '0 : SCREEN_MAX_Y - poll.raw_x[POS_Y_W-1:0];
		end
	end

	assign mapped.touch = poll.buffer_ready && (poll.point_count != 4'd0);
	assign mapped.pos.x = sx;
	assign mapped.pos.y = sy;
	assign mapped.time_ms = poll.time_ms;

endmodule

// ===== rtl/tgr_gesture_core.sv =====
// Press tracking, gesture decision and the result register.
// Depends on tgr_pkg.
module tgr_gesture_core
	import tgr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  gesture_cfg_t cfg,
	input  logic         valid_s1,
	input  mapped_poll_t poll_s1,
	output logic         advance,
	output logic         result_valid,
	input  logic         result_ready,
	output result_t      result_data
);

	logic               pressed_q;
	logic               long_done_q;
	point_t             start_q;
	logic [31:0]        start_time_q;
	point_t             recent_q;
	logic               out_valid_q;
	result_t            out_data_q;

	logic               take;
	logic [31:0]        elapsed;
	logic signed [9:0]  ldx;
	logic signed [8:0]  ldy;
	logic [9:0]         ldx_neg;
	logic [8:0]         ldy_neg;
	logic [8:0]         ladx;
	logic [7:0]         lady;
	logic [17:0]        sqx;
	logic [15:0]        sqy;
	logic [18:0]        dist_sq;
	logic               fire_long;
	logic signed [9:0]  rdx;
	logic signed [8:0]  rdy;
	logic [9:0]         rdx_neg;
	logic [8:0]         rdy_neg;
	logic [8:0]         radx;
	logic [7:0]         rady;
	logic               horiz;
	logic               is_left;
	logic               is_right;
	logic               is_tap;
	logic               fire;
	result_t            next_out;

	// The slot is free when it is empty or its result transfers this cycle.
	assign advance = !out_valid_q || result_ready;
	assign take = valid_s1 && advance && cfg.touch_enabled;

	// Long press check against the start of the press.
	always_comb begin
		elapsed = poll_s1.time_ms - start_time_q;
		ldx = $signed({1'b0, poll_s1.pos.x}) - $signed({1'b0, start_q.x});
		ldy = $signed({1'b0, poll_s1.pos.y}) - $signed({1'b0, start_q.y});
		ldx_neg = -ldx;
		ldy_neg = -ldy;
		ladx = ldx[9] ? ldx_neg[8:0] : ldx[8:0];
		lady = ldy[8] ? ldy_neg[7:0] : ldy[7:0];
		sqx = {9'd0, ladx} * {9'd0, ladx};
		sqy = {8'd0, lady} * {8'd0, lady};
		dist_sq = {1'b0, sqx} + {3'b0, sqy};
		fire_long = pressed_q && !long_done_q
			&& (elapsed >= {16'd0, cfg.hold_time})
			&& (dist_sq <= {3'b0, cfg.tap_tolerance_sq});
	end

	// Release classification from the last point of the press.
	always_comb begin
		rdx = $signed({1'b0, recent_q.x}) - $signed({1'b0, start_q.x});
		rdy = $signed({1'b0, recent_q.y}) - $signed({1'b0, start_q.y});
		rdx_neg = -rdx;
		rdy_neg = -rdy;
		radx = rdx[9] ? rdx_neg[8:0] : rdx[8:0];
		rady = rdy[8] ? rdy_neg[7:0] : rdy[7:0];
		horiz = {1'b0, rady} < radx;
		is_left = (rdx[9] || radx == 9'd0) && (radx >= cfg.swipe_travel) && horiz;
		is_right = !rdx[9] && (radx >= cfg.swipe_travel) && horiz;
		is_tap = (radx <= {1'b0, cfg.tap_tolerance}) && (rady <= cfg.tap_tolerance);
	end

	always_comb begin
		fire = 1'b0;
		next_out.gesture = G_TAP;
		next_out.pos_x = start_q.x;
		next_out.pos_y = start_q.y;
		if (poll_s1.touch) begin
			fire = fire_long;
			next_out.gesture = G_LONG;
		end else if (pressed_q && !long_done_q) begin
			if (is_left) begin
				fire = 1'b1;
				next_out.gesture = G_LEFT;
				next_out.pos_x = recent_q.x;
				next_out.pos_y = recent_q.y;
			end else if (is_right) begin
				fire = 1'b1;
				next_out.gesture = G_RIGHT;
				next_out.pos_x = recent_q.x;
				next_out.pos_y = recent_q.y;
			end else begin
				fire = is_tap;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= 1'b0;
			long_done_q <= 1'b0;
			start_q <= '0;
			start_time_q <= '0;
			recent_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= take && fire;
			end
			if (take) begin
				if (poll_s1.touch) begin
					if (!pressed_q) begin
						pressed_q <= 1'b1;
						long_done_q <= 1'b0;
						start_q <= poll_s1.pos;
						start_time_q <= poll_s1.time_ms;
					end else if (fire_long) begin
						long_done_q <= 1'b1;
					end
					recent_q <= poll_s1.pos;
				end else begin
					pressed_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take && fire) begin
			out_data_q <= next_out;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data = out_data_q;

endmodule

// ===== rtl/tgr_checker.sv =====
// Port-level checks for the touch gesture recognizer, bound to the top level.
// Depends on tgr_pkg and touch_gesture_recognizer_unit.
module tgr_checker
	import tgr_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    poll_valid,
	input logic    poll_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result_data
);

	// A result that is not taken stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// Only a stalled result can hold back polls.
	a_poll_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!poll_ready |-> result_valid && !result_ready)
		else $error("poll_ready low without a stalled result");

	// A fresh result follows a poll transfer through the poll stage and the result register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(poll_valid && poll_ready, 2))
		else $error("result without a matching poll transfer");

	// Reported positions lie on the landscape screen.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.pos_x <= SCREEN_MAX_X
			&& result_data.pos_y <= SCREEN_MAX_Y)
		else $error("result position off screen");

endmodule

bind touch_gesture_recognizer_unit tgr_checker u_tgr_checker (.*);
